### rtl/core/jhss_pkg.sv
// Shared types and constants for the two-joint homing settle supervisor.
// No dependencies; every other file of the block but jhss_skid refers to this package.
`timescale 1ns / 1ps

package jhss_pkg;

    // Angles are signed Q4.12 radians.
    localparam int ANGLE_W = 16;
    localparam int STEP_W  = 12;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_ARM  = 2'd2
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_TOL   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_NEEDED = 8'd3;

    localparam logic [STEP_W-1:0]  RAMP_STEP_RST    = 12'd41;
    localparam logic [STEP_W-1:0]  CHANGE_TOL_RST   = 12'd20;
    localparam logic [STEP_W-1:0]  ERROR_LIMIT_RST  = 12'd205;
    localparam logic [COUNT_W-1:0] TICKS_NEEDED_RST = 16'd50;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [ANGLE_W-1:0]  measured_a;
        logic signed [ANGLE_W-1:0]  measured_b;
        logic signed [ANGLE_W-1:0]  target_a;
        logic signed [ANGLE_W-1:0]  target_b;
    } t_in;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]  setpoint_a;
        logic signed [ANGLE_W-1:0]  setpoint_b;
        logic                       homed_flag;
        logic                       gain_select;
        logic [COUNT_W-1:0]         stable_ticks;
    } t_out;

endpackage

### rtl/core/joint_homing_settle_supervisor.sv
// Each accepted item's result is registered into the output buffer.
// Throughput: one item per cycle while the input is not stalled; the state
// update is a single pass of subtract-and-compare logic that closes within the
// accepting clock edge. The output buffer holds two results; input stalls only
// when both are full. Reset (synchronous, active low) zeroes setpoints, errors,
// counter and flags, restores the register defaults and empties the buffer.
`timescale 1ns / 1ps

module joint_homing_settle_supervisor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Item input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  jhss_pkg::t_in                       i_in_data,
    // Result output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output jhss_pkg::t_out                      o_out_data,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jhss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jhss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int W  = jhss_pkg::ANGLE_W;
    localparam int SW = jhss_pkg::STEP_W;
    localparam int CW = jhss_pkg::COUNT_W;

    // Moves a setpoint toward zero by one step and snaps it to zero once
    // it lies within the step. Work is done one bit wider so the negated
    // step and the comparisons cannot overflow.
    function automatic logic signed [W-1:0] f_ramp(
        input logic signed [W-1:0] sp,
        input logic signed [W:0]   st
    );
        logic signed [W:0] e;
        logic signed [W:0] r;
        e = (W+1)'(sp);
        if (e > st) begin
            r = e - st;
        end else if (e < -st) begin
            r = e + st;
        end else begin
            r = '0;
        end
        return r[W-1:0];
    endfunction

    // Absolute difference of two signed angles; it always fits in W bits.
    function automatic logic [W-1:0] f_abs_diff(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        logic signed [W:0] d;
        logic signed [W:0] m;
        d = (W+1)'(a) - (W+1)'(b);
        m = -d;
        return d[W] ? m[W-1:0] : d[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_abs_udiff(
        input logic [W-1:0] a,
        input logic [W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers. Writes are taken in any cycle.
    logic [SW-1:0] r_ramp_step;
    logic [SW-1:0] r_change_tol;
    logic [SW-1:0] r_error_limit;
    logic [CW-1:0] r_ticks_needed;

    // Supervisor state.
    logic signed [W-1:0] r_sp_a, n_sp_a;
    logic signed [W-1:0] r_sp_b, n_sp_b;
    logic [W-1:0]        r_perr_a, n_perr_a;
    logic [W-1:0]        r_perr_b, n_perr_b;
    logic [CW-1:0]       r_count, n_count;
    logic                r_homed, n_homed;
    logic                r_gains_on, n_gains_on;

    // Tick datapath.
    logic signed [W:0]   step_s;
    logic signed [W-1:0] tick_sp_a, tick_sp_b;
    logic [W-1:0]        err_a, err_b;
    logic                is_stable;
    logic [CW-1:0]       tick_count;
    logic                reached;

    logic                accept;
    logic                buf_full;
    jhss_pkg::t_in       in_d;
    jhss_pkg::t_out      result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid & ~buf_full;
    assign in_d        = i_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step    <= jhss_pkg::RAMP_STEP_RST;
            r_change_tol   <= jhss_pkg::CHANGE_TOL_RST;
            r_error_limit  <= jhss_pkg::ERROR_LIMIT_RST;
            r_ticks_needed <= jhss_pkg::TICKS_NEEDED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                jhss_pkg::REG_RAMP_STEP:    r_ramp_step    <= i_cfg_data[SW-1:0];
                jhss_pkg::REG_CHANGE_TOL:   r_change_tol   <= i_cfg_data[SW-1:0];
                jhss_pkg::REG_ERROR_LIMIT:  r_error_limit  <= i_cfg_data[SW-1:0];
                jhss_pkg::REG_TICKS_NEEDED: r_ticks_needed <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // A tick ramps both setpoints first and measures the errors against the
    // ramped values. The tick is stable only with both setpoints at zero,
    // both error changes under the tolerance and both errors under the limit.
    assign step_s    = signed'((W+1)'(r_ramp_step));
    assign tick_sp_a = f_ramp(r_sp_a, step_s);
    assign tick_sp_b = f_ramp(r_sp_b, step_s);
    assign err_a     = f_abs_diff(tick_sp_a, in_d.measured_a);
    assign err_b     = f_abs_diff(tick_sp_b, in_d.measured_b);

    assign is_stable = (tick_sp_a == '0) && (tick_sp_b == '0) &&
                       (f_abs_udiff(err_a, r_perr_a) < W'(r_change_tol)) &&
                       (f_abs_udiff(err_b, r_perr_b) < W'(r_change_tol)) &&
                       (err_a < W'(r_error_limit)) && (err_b < W'(r_error_limit));

    // The stable count saturates at its all-ones value and clears on any
    // unstable tick.
    assign tick_count = !is_stable ? '0 :
                        (&r_count) ? r_count : r_count + CW'(1);
    assign reached    = tick_count >= r_ticks_needed;

    always_comb begin
        n_sp_a     = r_sp_a;
        n_sp_b     = r_sp_b;
        n_perr_a   = r_perr_a;
        n_perr_b   = r_perr_b;
        n_count    = r_count;
        n_homed    = r_homed;
        n_gains_on = r_gains_on;
        if (accept) begin
            unique case (in_d.cmd)
                jhss_pkg::CMD_TICK: begin
                    n_sp_a     = tick_sp_a;
                    n_sp_b     = tick_sp_b;
                    n_perr_a   = err_a;
                    n_perr_b   = err_b;
                    n_count    = tick_count;
                    // Homing gains go on with every tick; reaching the count
                    // switches back to tracking gains. Homed stays set.
                    n_gains_on = ~reached;
                    n_homed    = r_homed | reached;
                end
                jhss_pkg::CMD_LOAD: begin
                    n_sp_a = in_d.target_a;
                    n_sp_b = in_d.target_b;
                end
                jhss_pkg::CMD_ARM: begin
                    n_perr_a = '0;
                    n_perr_b = '0;
                    n_homed  = 1'b0;
                end
                default: begin
                    // The unused command only reports the current state.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_a     <= '0;
            r_sp_b     <= '0;
            r_perr_a   <= '0;
            r_perr_b   <= '0;
            r_count    <= '0;
            r_homed    <= 1'b0;
            r_gains_on <= 1'b0;
        end else begin
            r_sp_a     <= n_sp_a;
            r_sp_b     <= n_sp_b;
            r_perr_a   <= n_perr_a;
            r_perr_b   <= n_perr_b;
            r_count    <= n_count;
            r_homed    <= n_homed;
            r_gains_on <= n_gains_on;
        end
    end

    // Every item reports the state it leaves behind.
    always_comb begin
        result.setpoint_a   = n_sp_a;
        result.setpoint_b   = n_sp_b;
        result.homed_flag   = n_homed;
        result.gain_select  = n_gains_on;
        result.stable_ticks = n_count;
    end

    jhss_skid #(
        .DATA_W ($bits(jhss_pkg::t_out))
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

### rtl/core/jhss_skid.sv
// Two-entry output buffer: a main output register plus one skid register.
// Generic over the data width; used by the supervisor top level.
`timescale 1ns / 1ps

module jhss_skid #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_data
);

    logic              r_main_valid, n_main_valid;
    logic              r_skid_valid, n_skid_valid;
    logic [DATA_W-1:0] r_main, n_main;
    logic [DATA_W-1:0] r_skid, n_skid;
    logic              pop;

    assign pop = r_main_valid & ~i_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
                if (i_push) begin
                    n_skid       = i_data;
                    n_skid_valid = 1'b1;
                end
            end else begin
                n_main_valid = i_push;
                n_main       = i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end else begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

### rtl/core/jhss_checker.sv
// Port-level checks for the homing settle supervisor, attached by bind.
// Depends on jhss_pkg for the payload types.
`timescale 1ns / 1ps

module jhss_port_checks (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input jhss_pkg::t_out o_out_data,
    input logic           o_cfg_ready
);

    // A result held back by the consumer stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or vanished");

    // Input is only held off when a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

    // The buffer fills only after the consumer held back a pending result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall && i_in_valid))
        else $error("input stall without a blocked transfer");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind joint_homing_settle_supervisor jhss_port_checks u_jhss_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

### verif/jhss_checker.sv
// Checker for the two-joint homing settle supervisor: predicts each result and compares it.
// Depends on jhss_pkg for the transfer structs, command codes and register indexes.
`timescale 1ns / 1ps

module jhss_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  jhss_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  jhss_pkg::t_out                  i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [jhss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jhss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import jhss_pkg::*;

    logic [STEP_W-1:0]         ramp_step;
    logic [STEP_W-1:0]         change_tol;
    logic [STEP_W-1:0]         error_limit;
    logic [COUNT_W-1:0]        ticks_needed;

    logic signed [ANGLE_W-1:0] sp_a;
    logic signed [ANGLE_W-1:0] sp_b;
    logic [ANGLE_W-1:0]        last_err_a;
    logic [ANGLE_W-1:0]        last_err_b;
    logic [COUNT_W-1:0]        settle_count;
    logic                      homed;
    logic                      homing_gains;

    t_out                      expected_reports[$];
    int                        fails = 0;

    function automatic logic signed [ANGLE_W-1:0] step_toward_zero(
        input logic signed [ANGLE_W-1:0] sp, input logic [STEP_W-1:0] step);
        int s;
        int st;
        logic signed [ANGLE_W-1:0] r;
        s = sp;
        st = step;
        if (s > st) begin
            r = ANGLE_W'(s - st);
        end else if (s < -st) begin
            r = ANGLE_W'(s + st);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [ANGLE_W-1:0] joint_error(
        input logic signed [ANGLE_W-1:0] sp, input logic signed [ANGLE_W-1:0] meas);
        int s;
        int m;
        int d;
        logic [ANGLE_W-1:0] r;
        s = sp;
        m = meas;
        d = s - m;
        if (d < 0) begin
            d = -d;
        end
        r = d[ANGLE_W-1:0];
        return r;
    endfunction

    function automatic bit error_steady(
        input logic [ANGLE_W-1:0] now_err, input logic [ANGLE_W-1:0] prev_err);
        int a;
        int b;
        int tol;
        a = now_err;
        b = prev_err;
        tol = change_tol;
        a = a - b;
        if (a < 0) begin
            a = -a;
        end
        return a < tol;
    endfunction

    // Applies one command to the predicted state and returns the report it yields.
    function automatic t_out advance_supervisor(input t_in item);
        logic signed [ANGLE_W-1:0] meas_a;
        logic signed [ANGLE_W-1:0] meas_b;
        logic [ANGLE_W-1:0]        err_a;
        logic [ANGLE_W-1:0]        err_b;
        logic                      settled;
        t_out                      r;
        case (item.cmd)
            CMD_TICK: begin
                meas_a = item.measured_a;
                meas_b = item.measured_b;
                homing_gains = 1'b1;
                sp_a = step_toward_zero(sp_a, ramp_step);
                sp_b = step_toward_zero(sp_b, ramp_step);
                err_a = joint_error(sp_a, meas_a);
                err_b = joint_error(sp_b, meas_b);
                settled = (sp_a == 0) && (sp_b == 0) &&
                          error_steady(err_a, last_err_a) &&
                          error_steady(err_b, last_err_b) &&
                          (err_a < error_limit) && (err_b < error_limit);
                if (!settled) begin
                    settle_count = '0;
                end else if (settle_count != '1) begin
                    settle_count = settle_count + 1'b1;
                end
                last_err_a = err_a;
                last_err_b = err_b;
                if (settle_count >= ticks_needed) begin
                    homed = 1'b1;
                    homing_gains = 1'b0;
                end
            end
            CMD_LOAD: begin
                sp_a = item.target_a;
                sp_b = item.target_b;
            end
            CMD_ARM: begin
                last_err_a = '0;
                last_err_b = '0;
                homed = 1'b0;
            end
            default: begin
            end
        endcase
        r.setpoint_a = sp_a;
        r.setpoint_b = sp_b;
        r.homed_flag = homed;
        r.gain_select = homing_gains;
        r.stable_ticks = settle_count;
        return r;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            fails++;
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            ramp_step = RAMP_STEP_RST;
            change_tol = CHANGE_TOL_RST;
            error_limit = ERROR_LIMIT_RST;
            ticks_needed = TICKS_NEEDED_RST;
            sp_a = '0;
            sp_b = '0;
            last_err_a = '0;
            last_err_b = '0;
            settle_count = '0;
            homed = 1'b0;
            homing_gains = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RAMP_STEP:    ramp_step = i_cfg_data[STEP_W-1:0];
                    REG_CHANGE_TOL:   change_tol = i_cfg_data[STEP_W-1:0];
                    REG_ERROR_LIMIT:  error_limit = i_cfg_data[STEP_W-1:0];
                    REG_TICKS_NEEDED: ticks_needed = i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            // A result leaving this cycle always belongs to an earlier transfer,
            // so it is retired before the incoming command is predicted.
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    fails++;
                    $error("result transfer with no prediction pending");
                end else begin
                    exp_r = expected_reports.pop_front();
                    check_field("setpoint_a", $signed(exp_r.setpoint_a),
                                $signed(i_out_data.setpoint_a));
                    check_field("setpoint_b", $signed(exp_r.setpoint_b),
                                $signed(i_out_data.setpoint_b));
                    check_field("homed_flag", exp_r.homed_flag, i_out_data.homed_flag);
                    check_field("gain_select", exp_r.gain_select, i_out_data.gain_select);
                    check_field("stable_ticks", exp_r.stable_ticks, i_out_data.stable_ticks);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_reports.push_back(advance_supervisor(i_in_data));
            end
        end
        o_pending <= expected_reports.size();
        o_fail_count <= fails;
    end

endmodule

### verif/joint_homing_settle_supervisor_tb.sv
// Top of the testbench for the two-joint homing settle supervisor: clock, reset and stimulus.
// Depends on jhss_pkg, the block itself and jhss_checker, which predicts and compares results.
`timescale 1ns / 1ps

module joint_homing_settle_supervisor_tb;
    import jhss_pkg::*;

    // The command encoding leaves one code unused; the block must report its
    // state unchanged for it. Likewise one register index outside the map.
    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_TICKS = 9;
    // Longest stretch with no transfer on any channel before the run is declared hung.
    // Sender gaps and receiver stall runs are both far shorter than this.
    localparam int IDLE_LIMIT  = 1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;

    // When calm is set, neither the sender nor the receiver idles.
    bit calm = 1'b0;
    int burst_left = 0;
    int stall_run = 0;
    int idle_cycles = 0;

    joint_homing_settle_supervisor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    jhss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // The receiver stalls in runs of random length, independent of what it is
    // offered, so that stalls land on every phase of the sender's bursts.
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run == 0) begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_run <= $urandom_range(1, 6);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // Watchdog: a handshake on any channel resets the count of dead cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one command and returns at the edge where it is transferred.
    // Valid stays high into the next call unless a gap opens a new burst,
    // so it is never lowered and raised in the same time step.
    task automatic issue(input logic [1:0] cmd, input int a, input int b);
        t_in item;
        int gap;
        item.cmd = cmd;
        item.measured_a = ANGLE_W'($urandom);
        item.measured_b = ANGLE_W'($urandom);
        item.target_a = ANGLE_W'($urandom);
        item.target_b = ANGLE_W'($urandom);
        // The two angle arguments fill whichever pair the command consumes;
        // the other pair carries noise that the block has to ignore.
        if (cmd == CMD_LOAD) begin
            item.target_a = a[ANGLE_W-1:0];
            item.target_b = b[ANGLE_W-1:0];
        end else if (cmd == CMD_TICK) begin
            item.measured_a = a[ANGLE_W-1:0];
            item.measured_b = b[ANGLE_W-1:0];
        end
        if (burst_left == 0) begin
            gap = 0;
            if (!calm && $urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 12);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Holds the sender off until every predicted result has been transferred.
    // Each command yields exactly one result, so an empty prediction store means
    // the block is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes all four registers back to back, optionally followed by a write to
    // an index outside the register map, which the block must ignore.
    task automatic program_regs(input int step, input int tol, input int lim,
                                input int ticks, input bit with_unused);
        logic [CFG_IDX_W-1:0] idx_list[0:4];
        int                   val_list[0:4];
        int                   count;
        idx_list[0] = REG_RAMP_STEP;
        idx_list[1] = REG_CHANGE_TOL;
        idx_list[2] = REG_ERROR_LIMIT;
        idx_list[3] = REG_TICKS_NEEDED;
        idx_list[4] = REG_UNUSED;
        val_list[0] = step;
        val_list[1] = tol;
        val_list[2] = lim;
        val_list[3] = ticks;
        val_list[4] = $urandom;
        count = with_unused ? 5 : 4;
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < count; k++) begin
            i_cfg_index <= idx_list[k];
            i_cfg_data <= val_list[k][CFG_DATA_W-1:0];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed homing attempts: load setpoints near zero, often re-arm,
    // then a run of ticks with measurements hugging zero so that the settle
    // counter climbs. The rest is unstructured commands and mid-phase pauses.
    task automatic random_phase(input int n_items);
        int done;
        int pick;
        int ta;
        int tb;
        int amp;
        int span;
        int ticks;
        int ma;
        int mb;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                calm = ($urandom_range(0, 4) == 0);
                span = ($urandom_range(0, 3) == 0) ? 2000 : 300;
                ta = $urandom_range(0, 2 * span) - span;
                tb = $urandom_range(0, 2 * span) - span;
                if ($urandom_range(0, 9) == 0) begin
                    ta = $urandom;
                end
                issue(CMD_LOAD, ta, tb);
                done++;
                if ($urandom_range(0, 1) == 1) begin
                    issue(CMD_ARM, 0, 0);
                    done++;
                end
                ticks = $urandom_range(3, 40);
                amp = $urandom_range(0, 15);
                for (int k = 0; k < ticks; k++) begin
                    ma = $urandom_range(0, 2 * amp) - amp;
                    mb = $urandom_range(0, 2 * amp) - amp;
                    // An occasional jolt on one joint breaks the settle streak.
                    if ($urandom_range(0, 19) == 0) begin
                        ma = $urandom_range(0, 600) - 300;
                    end
                    issue(CMD_TICK, ma, mb);
                end
                done += ticks;
                calm = 1'b0;
            end else if (pick < 18) begin
                pick = $urandom_range(0, 3);
                issue(pick[1:0], $urandom, $urandom);
                done++;
            end else if (pick == 18) begin
                issue(CMD_ARM, 0, 0);
                done++;
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset register values (step 41, tolerance 20,
        // limit 205, 50 ticks needed).
        issue(CMD_TICK, 0, 0);            // settled from reset: count starts
        issue(CMD_TICK, 5, -5);           // small change, still settled
        issue(CMD_TICK, 30, 0);           // change of 25 breaks the streak
        issue(CMD_LOAD, -32768, 32767);   // setpoint extremes
        issue(CMD_TICK, 32767, -32768);   // measurement extremes, widest error
        issue(CMD_TICK, 0, 0);
        issue(CMD_UNUSED, $urandom, $urandom);
        issue(CMD_ARM, 0, 0);
        issue(CMD_LOAD, 41, -41);         // exactly one step away: snaps to zero
        issue(CMD_TICK, 0, 0);
        issue(CMD_LOAD, 42, -42);         // one past the step: ramps, then snaps
        issue(CMD_TICK, 0, 0);
        issue(CMD_TICK, 0, 0);
        issue(CMD_LOAD, 16'h5555, 16'hAAAA);
        issue(CMD_TICK, 16'hAAAA, 16'h5555);
        issue(CMD_LOAD, 0, 0);
        issue(CMD_TICK, 204, -204);       // error just under the limit
        issue(CMD_TICK, 204, -204);       // unchanged, so settled
        issue(CMD_TICK, 205, 0);          // error at the limit is not settled
        issue(CMD_ARM, 0, 0);
        issue(CMD_TICK, 0, 0);
        issue(CMD_TICK, 19, 0);           // change just under the tolerance
        issue(CMD_TICK, 39, 0);           // change equal to the tolerance
        issue(CMD_TICK, 39, 0);
        drain();

        // Reset-like gains with a short settle requirement so homing completes.
        program_regs(41, 20, 205, 5, 1'b0);
        random_phase(300);
        drain();

        // Zero step and zero ticks needed, widest tolerance and limit: nonzero
        // setpoints never move and every tick declares homing done.
        program_regs(0, 4095, 4095, 0, 1'b1);
        random_phase(150);
        drain();

        // Largest step, zero tolerance and limit: nothing ever settles.
        program_regs(4095, 0, 0, 1, 1'b0);
        random_phase(150);
        drain();

        program_regs($urandom_range(1, 300), $urandom_range(4, 60),
                     $urandom_range(20, 400), $urandom_range(1, 30), 1'b0);
        random_phase(300);
        drain();

        program_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(1, 40), 1'b0);
        random_phase(250);
        drain();

        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
